[hw/rtl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// hce_pkg
// Shared widths and codes for the Hamiltonian cycle enumerator.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int VERT_W    = 5;
  localparam int FUNC_W    = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_EDGE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd2;

  // result codes
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'd1;

  typedef enum logic [1:0] {
    PH_FRESH   = 2'd0,
    PH_EMITTED = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

endpackage

[hw/rtl/hce_if.sv]
// ----------------------------------------------------------------------------
// hce_in_if / hce_out_if
// Valid/ready channels for requests and results of the cycle enumerator.
// ----------------------------------------------------------------------------
interface hce_in_if;
  logic                        valid;
  logic                        ready;
  logic [hce_pkg::FUNC_W-1:0]  func;
  logic [hce_pkg::VERT_W-1:0]  row_vertex;
  logic [hce_pkg::VERT_W-1:0]  col_vertex;
  logic                        edge_present;

  modport source (output valid, func, row_vertex, col_vertex, edge_present, input ready);
  modport sink   (input valid, func, row_vertex, col_vertex, edge_present, output ready);
endinterface

interface hce_out_if;
  logic                        valid;
  logic                        ready;
  logic [hce_pkg::KIND_W-1:0]  kind;
  logic [hce_pkg::VERT_W-1:0]  vertex;
  logic                        last;

  modport source (output valid, kind, vertex, last, input ready);
  modport sink   (input valid, kind, vertex, last, output ready);
endinterface

[hw/rtl/hamiltonian_cycle_enumerator.sv]
// ----------------------------------------------------------------------------
// hamiltonian_cycle_enumerator
// Depth-first backtracking search for Hamiltonian cycles from a start vertex.
// ----------------------------------------------------------------------------
// Requests enter on in_i (valid/ready), results leave on out_o through one
// output register. An edge write or restart answers one acknowledge, and
// a next request answers a run of vertex results, the final one flagged
// last, or a single exhausted result.
// Search time depends on the graph: each candidate vertex is tested in turn,
// a step down a level reads the new adjacency row, a step back makes two
// stack reads and one adjacency read, each over a registered memory port,
// then emitted vertices leave one per cycle while out_o keeps ready high.
// Adjacency rows and the path/candidate stack sit in two RAMs; every access
// is sequenced by the controller, so no two ever touch the same entry at once.
// One request is worked at a time; in_i is ready only while the controller
// is idle, even while an earlier result still waits in the output register.
// When out_o stalls, the controller holds until the transfer completes.
// Reset clears all edges through per-row valid flops at once (no clearing
// pass), sets vertex_count to 4, start_vertex to 1 and the search to fresh.
// A configuration write also returns the search to fresh.
// ----------------------------------------------------------------------------
module hamiltonian_cycle_enumerator #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hce_pkg::CFG_DAT_W-1:0] cfg_data_i,
  hce_in_if.sink                        in_i,
  hce_out_if.source                     out_o
);

  localparam int LW = hce_pkg::VERT_W;
  localparam int AW = $clog2(MAX_VERTICES);

  typedef logic [LW-1:0]           lbl_t;
  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_FIND = 12'b0000_0000_0010,
    S_SROW = 12'b0000_0000_0100,
    S_SCAN = 12'b0000_0000_1000,
    S_ROW  = 12'b0000_0001_0000,
    S_BT1  = 12'b0000_0010_0000,
    S_BT2  = 12'b0000_0100_0000,
    S_EMIT = 12'b0000_1000_0000,
    S_DONE = 12'b0001_0000_0000,
    S_ACK  = 12'b0010_0000_0000,
    S_EW1  = 12'b0100_0000_0000,
    S_EW2  = 12'b1000_0000_0000
  } state_e;

  function automatic logic [AW-1:0] lbl_idx(lbl_t v);
    lbl_idx = AW'(v - 1'b1);
  endfunction

  function automatic logic lbl_ok(lbl_t v);
    lbl_ok = (v != '0) && (32'(v) <= MAX_VERTICES);
  endfunction

  function automatic row_t put_bit(row_t row, logic [AW-1:0] idx, logic val);
    row_t r;
    r      = row;
    r[idx] = val;
    put_bit = r;
  endfunction

  state_e          state_q, state_d;
  hce_pkg::phase_e phase_q, phase_d;

  lbl_t cfg_vc_q, cfg_sv_q;
  lbl_t n_lim;

  lbl_t depth_q, depth_d;
  lbl_t cur_c_q, cur_c_d;
  lbl_t emit_idx_q, emit_idx_d;
  row_t prev_row_q, prev_row_d;
  row_t start_row_q, start_row_d;
  row_t visited_q, visited_d;
  row_t row_valid_q, row_valid_d;
  logic adj_rvalid_q;

  lbl_t ew_row_q, ew_col_q;
  logic ew_set_q;

  logic                      out_valid_q, out_valid_d;
  logic [hce_pkg::KIND_W-1:0] out_kind_q, out_kind_d;
  lbl_t                      out_vert_q, out_vert_d;
  logic                      out_last_q, out_last_d;
  logic                      out_load, out_free;

  logic          adj_we, adj_re;
  logic [AW-1:0] adj_waddr, adj_raddr;
  row_t          adj_wdata, adj_rdata, adj_row;

  logic            stk_we, stk_re;
  logic [AW-1:0]   stk_waddr, stk_raddr;
  logic [2*LW-1:0] stk_wdata, stk_rdata;
  lbl_t            stk_path, stk_cand;

  logic          in_xfer;
  logic [AW-1:0] ci;
  logic          cand_ok;

  hce_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .re_i   (adj_re),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  hce_ram #(.WIDTH(2 * LW), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  // a row never written reads as no edges
  assign adj_row  = adj_rvalid_q ? adj_rdata : '0;
  assign stk_path = stk_rdata[2*LW-1:LW];
  assign stk_cand = stk_rdata[LW-1:0];

  assign n_lim = (32'(cfg_vc_q) > MAX_VERTICES) ? LW'(MAX_VERTICES) : cfg_vc_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign ci      = lbl_idx(cur_c_q);
  assign cand_ok = !visited_q[ci] && prev_row_q[ci] &&
                   ((depth_q != n_lim - 1'b1) || start_row_q[ci]);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    depth_d     = depth_q;
    cur_c_d     = cur_c_q;
    emit_idx_d  = emit_idx_q;
    prev_row_d  = prev_row_q;
    start_row_d = start_row_q;
    visited_d   = visited_q;
    row_valid_d = row_valid_q;
    adj_we      = 1'b0;
    adj_waddr   = '0;
    adj_wdata   = '0;
    adj_re      = 1'b0;
    adj_raddr   = '0;
    stk_we      = 1'b0;
    stk_waddr   = '0;
    stk_wdata   = '0;
    stk_re      = 1'b0;
    stk_raddr   = '0;
    out_load    = 1'b0;
    out_kind_d  = hce_pkg::KIND_ACK;
    out_vert_d  = '0;
    out_last_d  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.func)
            hce_pkg::FUNC_EDGE: begin
              phase_d = hce_pkg::PH_FRESH;
              if (lbl_ok(in_i.row_vertex) && lbl_ok(in_i.col_vertex) &&
                  (in_i.row_vertex != in_i.col_vertex)) begin
                adj_re    = 1'b1;
                adj_raddr = lbl_idx(in_i.row_vertex);
                state_d   = S_EW1;
              end else begin
                state_d = S_ACK;
              end
            end
            hce_pkg::FUNC_RESTART: begin
              phase_d = hce_pkg::PH_FRESH;
              state_d = S_ACK;
            end
            hce_pkg::FUNC_NEXT: begin
              state_d = S_FIND;
            end
            default: begin
              // spare code: acknowledge, leave the search where it was
              state_d = S_ACK;
            end
          endcase
        end
      end
      S_EW1: begin
        adj_we                 = 1'b1;
        adj_waddr              = lbl_idx(ew_row_q);
        adj_wdata              = put_bit(adj_row, lbl_idx(ew_col_q), ew_set_q);
        row_valid_d[adj_waddr] = 1'b1;
        adj_re                 = 1'b1;
        adj_raddr              = lbl_idx(ew_col_q);
        state_d                = S_EW2;
      end
      S_EW2: begin
        adj_we                 = 1'b1;
        adj_waddr              = lbl_idx(ew_col_q);
        adj_wdata              = put_bit(adj_row, lbl_idx(ew_row_q), ew_set_q);
        row_valid_d[adj_waddr] = 1'b1;
        state_d                = S_ACK;
      end
      S_FIND: begin
        if (n_lim == '0 || cfg_sv_q == '0 || cfg_sv_q > n_lim ||
            phase_q == hce_pkg::PH_DONE) begin
          phase_d = hce_pkg::PH_DONE;
          state_d = S_DONE;
        end else if (phase_q == hce_pkg::PH_FRESH) begin
          stk_we                      = 1'b1;
          stk_waddr                   = '0;
          stk_wdata                   = {cfg_sv_q, LW'(0)};
          visited_d                   = '0;
          visited_d[lbl_idx(cfg_sv_q)] = 1'b1;
          depth_d                     = LW'(1);
          cur_c_d                     = LW'(1);
          adj_re                      = 1'b1;
          adj_raddr                   = lbl_idx(cfg_sv_q);
          state_d                     = S_SROW;
        end else if (depth_q <= LW'(1) || depth_q > n_lim) begin
          phase_d = hce_pkg::PH_DONE;
          state_d = S_DONE;
        end else begin
          // resume: undo the last placement
          stk_re    = 1'b1;
          stk_raddr = AW'(depth_q - 1'b1);
          depth_d   = depth_q - 1'b1;
          state_d   = S_BT1;
        end
      end
      S_SROW: begin
        start_row_d = adj_row;
        prev_row_d  = adj_row;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        if (depth_q >= n_lim) begin
          stk_re     = 1'b1;
          stk_raddr  = '0;
          emit_idx_d = '0;
          state_d    = S_EMIT;
        end else if (cur_c_q == '0 || cur_c_q > n_lim) begin
          if (depth_q <= LW'(1)) begin
            phase_d = hce_pkg::PH_DONE;
            state_d = S_DONE;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = AW'(depth_q - 1'b1);
            depth_d   = depth_q - 1'b1;
            state_d   = S_BT1;
          end
        end else if (cand_ok) begin
          stk_we        = 1'b1;
          stk_waddr     = AW'(depth_q);
          stk_wdata     = {cur_c_q, cur_c_q + 1'b1};
          visited_d[ci] = 1'b1;
          depth_d       = depth_q + 1'b1;
          cur_c_d       = LW'(1);
          adj_re        = 1'b1;
          adj_raddr     = ci;
          state_d       = S_ROW;
        end else begin
          cur_c_d = cur_c_q + 1'b1;
        end
      end
      S_ROW: begin
        prev_row_d = adj_row;
        state_d    = S_SCAN;
      end
      S_BT1: begin
        // drop the vertex at this level, resume at its next candidate
        visited_d[lbl_idx(stk_path)] = 1'b0;
        cur_c_d                      = stk_cand;
        stk_re                       = 1'b1;
        stk_raddr                    = AW'(depth_q - 1'b1);
        state_d                      = S_BT2;
      end
      S_BT2: begin
        adj_re    = 1'b1;
        adj_raddr = lbl_idx(stk_path);
        state_d   = S_ROW;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = hce_pkg::KIND_VERTEX;
          out_vert_d = stk_path;
          out_last_d = (LW'(emit_idx_q + 1'b1) == n_lim);
          if (out_last_d) begin
            phase_d = hce_pkg::PH_EMITTED;
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            stk_re     = 1'b1;
            stk_raddr  = AW'(emit_idx_q + 1'b1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = hce_pkg::KIND_NONE;
          state_d    = S_IDLE;
        end
      end
      S_ACK: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      phase_d = hce_pkg::PH_FRESH;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= hce_pkg::PH_FRESH;
      cfg_vc_q     <= LW'(4);
      cfg_sv_q     <= LW'(1);
      depth_q      <= LW'(1);
      cur_c_q      <= LW'(1);
      emit_idx_q   <= '0;
      visited_q    <= '0;
      row_valid_q  <= '0;
      adj_rvalid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      depth_q     <= depth_d;
      cur_c_q     <= cur_c_d;
      emit_idx_q  <= emit_idx_d;
      visited_q   <= visited_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
      if (adj_re) begin
        adj_rvalid_q <= row_valid_q[adj_raddr];
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hce_pkg::CFG_VERTEX_COUNT: cfg_vc_q <= LW'(cfg_data_i);
          hce_pkg::CFG_START_VERTEX: cfg_sv_q <= LW'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_row_q  <= prev_row_d;
    start_row_q <= start_row_d;
    if (in_xfer) begin
      ew_row_q <= in_i.row_vertex;
      ew_col_q <= in_i.col_vertex;
      ew_set_q <= in_i.edge_present;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_vert_q <= out_vert_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.kind   = out_kind_q;
  assign out_o.vertex = out_vert_q;
  assign out_o.last   = out_last_q;

endmodule

[hw/rtl/hce_ram.sv]
// ----------------------------------------------------------------------------
// hce_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
